// ===== rtl/vgg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the Gaussian axis table of the visibility gridder.
// Depends on nothing; every other file of the block but vgg_ram imports it.
package vgg_pkg;

    // Sizes of the block.
    localparam int GRID_SIDE_MAX_DEF = 256;
    localparam int KERNEL_SIZE       = 7;
    localparam int FRAC_STEPS        = 16;
    localparam int HALF_K            = KERNEL_SIZE / 2;
    localparam int GTAB_LEN          = (HALF_K + 1) * FRAC_STEPS + 1;
    localparam int D_W               = $clog2(GTAB_LEN);
    localparam int FQ_W              = $clog2(FRAC_STEPS) + 2;
    localparam int TAP_W             = $clog2(KERNEL_SIZE);
    localparam int SIDE_MIN          = 8;

    // Field and datapath widths.
    localparam int CPU_W   = 16;
    localparam int SIDE_W  = 9;
    localparam int COORD_W = 32;
    localparam int DIN_W   = 24;
    localparam int ACC_W   = 40;
    localparam int CELL_W  = 8;
    localparam int G_W     = 16;
    localparam int WT_W    = 2 * G_W;
    localparam int PROD_W  = DIN_W + WT_W + 1;
    localparam int C_W     = PROD_W - WT_W;
    localparam int FRAC_W  = 24;
    localparam int POS_W   = 50;
    localparam int IPM_W   = POS_W - 1 - FRAC_W;
    localparam int BIT_W   = $clog2(IPM_W);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_CPU  = 1'b0;
    localparam logic REG_SIDE = 1'b1;
    localparam logic [CPU_W-1:0]  CPU_RESET  = 16'd512;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd160;

    // Operation codes and axis selection.
    localparam logic OP_GRID  = 1'b0;
    localparam logic OP_READ  = 1'b1;
    localparam logic AXIS_ROW = 1'b0;
    localparam logic AXIS_COL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             mul;
        logic             split;
        logic             div_init;
        logic             div_step;
        logic             div_store;
        logic             div_axis;
        logic             cell_addr;
        logic [TAP_W-1:0] tap_m;
        logic [TAP_W-1:0] tap_l;
        logic             mem_re;
        logic             prod;
        logic             acc_we;
        logic             rd_addr;
        logic             out_load;
        logic             clr_we;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } sts_t;

    typedef logic [G_W-1:0] gtab_t [GTAB_LEN];

    // One entry of the per-axis Gaussian table, unsigned Q0.16.
    function automatic logic [G_W-1:0] gauss_q16(input int unsigned n);
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] z3;
        logic [63:0] a;
        y = ((64'd2 * 64'(n) * 64'(n)) << 31) / 64'(FRAC_STEPS * FRAC_STEPS);
        if (y >= (64'd32 << 31))
        begin
            return '0;
        end
        z  = y >> 10;
        z2 = (z * z) >> 31;
        z3 = (z2 * z) >> 31;
        a  = (64'd1 << 31) - z + z2 / 64'd2 - z3 / 64'd6;
        for (int i = 0; i < 10; i++)
        begin
            a = (a * a) >> 31;
        end
        return G_W'((a * 64'd52291 + (64'd1 << 30)) >> 31);
    endfunction

    function automatic gtab_t build_gtab();
        gtab_t t;
        for (int n = 0; n < GTAB_LEN; n++)
        begin
            t[n] = gauss_q16(n);
        end
        return t;
    endfunction

    localparam gtab_t GTAB = build_gtab();

    // Table value for tap k given the quantised fraction of the position.
    function automatic logic [G_W-1:0] axis_weight(input logic [TAP_W-1:0] k,
                                                   input logic signed [FQ_W-1:0] fq);
        int d;
        d = (int'(k) - HALF_K) * FRAC_STEPS - int'(fq);
        if (d < 0)
        begin
            d = -d;
        end
        if (d >= GTAB_LEN)
        begin
            return '0;
        end
        return GTAB[D_W'(d)];
    endfunction

endpackage

// ===== rtl/vgg_item_if.sv =====
`timescale 1ns / 1ps
// Input channel of the gridder: valid/ready handshake and one input word.
// Depends on vgg_pkg for field widths.
interface vgg_item_if;
    import vgg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
    logic signed [DIN_W-1:0]   vis_re;
    logic signed [DIN_W-1:0]   vis_im;
    logic signed [DIN_W-1:0]   wgt_re;
    logic signed [DIN_W-1:0]   wgt_im;
    logic [CELL_W-1:0]         cell_row;
    logic [CELL_W-1:0]         cell_col;

    modport source (output valid, operation, u_coord, v_coord, vis_re, vis_im,
                    wgt_re, wgt_im, cell_row, cell_col, input ready);
    modport sink (input valid, operation, u_coord, v_coord, vis_re, vis_im,
                  wgt_re, wgt_im, cell_row, cell_col, output ready);
endinterface

// ===== rtl/vgg_result_if.sv =====
`timescale 1ns / 1ps
// Result channel of the gridder: valid/ready handshake and one cell word.
// Depends on vgg_pkg for field widths.
interface vgg_result_if;
    import vgg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] uv_re;
    logic signed [ACC_W-1:0] uv_im;
    logic signed [ACC_W-1:0] bm_re;
    logic signed [ACC_W-1:0] bm_im;

    modport source (output valid, uv_re, uv_im, bm_re, bm_im, input ready);
    modport sink (input valid, uv_re, uv_im, bm_re, bm_im, output ready);
endinterface

// ===== rtl/visibility_gaussian_gridder.sv =====
`timescale 1ns / 1ps
// Top level of the Gaussian visibility gridder: configuration registers,
// controller and datapath. Depends on vgg_pkg, the channel interfaces,
// vgg_ctrl and vgg_dp.
//
// Usage: words arrive on the item channel (valid/ready). A grid word scatters
// a 7x7 Gaussian footprint of the visibility into the data grid and of the
// weight into the beam grid; it produces no result word. A read word returns
// one cell of both grids on the result channel and clears that cell.
// A grid word occupies the block from acceptance to the next ready: the set-up
// steps (multiply, split), two passes of the bit-serial modulo unit that wraps
// the row and column, and a read-modify-write of each of the 49 footprint cells
// (address, read, multiply, write).
// A read word gives its result after an address and a read step, once the output register is free.
// After reset the four grids are cleared one cell per cycle, covering all
// GRID_SIDE_MAX*GRID_SIDE_MAX cells (65536 by default); no item is taken
// meanwhile, while register writes are accepted throughout.
// The result is held in an output register: grid words are still accepted while
// it waits, and a further read waits until the receiver has taken it.
// Registers: cells_per_unit at byte 0, grid_side at byte 4.
module visibility_gaussian_gridder #(
    parameter int GRID_SIDE_MAX = vgg_pkg::GRID_SIDE_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vgg_pkg::PADDR_W-1:0]   paddr,
    input  logic [vgg_pkg::PDATA_W-1:0]   pwdata,
    output logic [vgg_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    vgg_item_if.sink                      item,
    vgg_result_if.source                  result
);
    import vgg_pkg::*;

    logic [CPU_W-1:0]  cells_per_unit_reg;
    logic [SIDE_W-1:0] grid_side_reg;
    logic              cfg_we;
    cmd_t              cmd;
    sts_t              sts;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_per_unit_reg <= CPU_RESET;
            grid_side_reg      <= SIDE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[PADDR_W-1])
                REG_CPU:  cells_per_unit_reg <= pwdata[CPU_W-1:0];
                REG_SIDE: grid_side_reg      <= pwdata[SIDE_W-1:0];
                default:  ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[PADDR_W-1])
            REG_CPU:  prdata = PDATA_W'(cells_per_unit_reg);
            REG_SIDE: prdata = PDATA_W'(grid_side_reg);
            default:  prdata = '0;
        endcase
    end

    vgg_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item.valid),
        .item_operation (item.operation),
        .item_ready     (item.ready),
        .result_valid   (result.valid),
        .result_ready   (result.ready),
        .sts            (sts),
        .cmd            (cmd)
    );

    vgg_dp #(
        .GRID_SIDE_MAX (GRID_SIDE_MAX)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cells_per_unit (cells_per_unit_reg),
        .grid_side      (grid_side_reg),
        .u_coord        (item.u_coord),
        .v_coord        (item.v_coord),
        .vis_re         (item.vis_re),
        .vis_im         (item.vis_im),
        .wgt_re         (item.wgt_re),
        .wgt_im         (item.wgt_im),
        .cell_row       (item.cell_row),
        .cell_col       (item.cell_col),
        .uv_re          (result.uv_re),
        .uv_im          (result.uv_im),
        .bm_re          (result.bm_re),
        .bm_im          (result.bm_im)
    );

    // No word is taken while the grids are being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_we |-> !item.ready)
        else $error("item accepted during grid clearing");

    // A new result only ever follows the completion of a read.
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.out_load))
        else $error("result raised without a completed read");

    // The RAM port is never read while an accumulate or clear write is under way.
    a_read_write_apart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_re |-> (!cmd.acc_we && !cmd.clr_we && !cmd.out_load))
        else $error("grid read collides with a grid write");
endmodule

// ===== rtl/vgg_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for each of the four accumulator grids.
module vgg_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/vgg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the gridder: sequences clearing, position set-up, the modulo
// unit, the footprint walk and cell reads. Depends on vgg_pkg.
module vgg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  logic          item_operation,
    output logic          item_ready,
    output logic          result_valid,
    input  logic          result_ready,
    input  vgg_pkg::sts_t sts,
    output vgg_pkg::cmd_t cmd
);
    import vgg_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SPLIT,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_STORE,
        S_CELL_ADDR,
        S_CELL_READ,
        S_CELL_MUL,
        S_CELL_WRITE,
        S_RD_ADDR,
        S_RD_READ,
        S_RD_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic             axis_reg, axis_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [TAP_W-1:0] tap_m_reg, tap_m_next;
    logic [TAP_W-1:0] tap_l_reg, tap_l_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        bit_next       = bit_reg;
        tap_m_next     = tap_m_reg;
        tap_l_next     = tap_l_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        cmd.tap_m      = tap_m_reg;
        cmd.tap_l      = tap_l_reg;
        cmd.div_axis   = axis_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = (item_operation == OP_READ) ? S_RD_ADDR : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                axis_next  = AXIS_ROW;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                bit_next     = '0;
                state_next   = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + 1'b1;
                if (bit_reg == BIT_W'(IPM_W - 1))
                begin
                    state_next = S_DIV_STORE;
                end
            end
            S_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                if (axis_reg == AXIS_ROW)
                begin
                    axis_next  = AXIS_COL;
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    tap_m_next = '0;
                    tap_l_next = '0;
                    state_next = S_CELL_ADDR;
                end
            end
            S_CELL_ADDR:
            begin
                cmd.cell_addr = 1'b1;
                state_next    = S_CELL_READ;
            end
            S_CELL_READ:
            begin
                cmd.mem_re = 1'b1;
                state_next = S_CELL_MUL;
            end
            S_CELL_MUL:
            begin
                cmd.prod   = 1'b1;
                state_next = S_CELL_WRITE;
            end
            S_CELL_WRITE:
            begin
                cmd.acc_we = 1'b1;
                state_next = S_CELL_ADDR;
                if (tap_l_reg == TAP_W'(KERNEL_SIZE - 1))
                begin
                    tap_l_next = '0;
                    if (tap_m_reg == TAP_W'(KERNEL_SIZE - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tap_m_next = tap_m_reg + 1'b1;
                    end
                end
                else
                begin
                    tap_l_next = tap_l_reg + 1'b1;
                end
            end
            S_RD_ADDR:
            begin
                cmd.rd_addr = 1'b1;
                state_next  = S_RD_READ;
            end
            S_RD_READ:
            begin
                cmd.mem_re = 1'b1;
                state_next = S_RD_DONE;
            end
            S_RD_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            axis_reg      <= AXIS_ROW;
            bit_reg       <= '0;
            tap_m_reg     <= '0;
            tap_l_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            bit_reg       <= bit_next;
            tap_m_reg     <= tap_m_next;
            tap_l_reg     <= tap_l_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== rtl/vgg_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the gridder: position arithmetic, the bit-serial modulo unit,
// footprint weights, saturating accumulation and the four grid RAMs.
// Depends on vgg_pkg and vgg_ram.
module vgg_dp #(
    parameter int GRID_SIDE_MAX = vgg_pkg::GRID_SIDE_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vgg_pkg::cmd_t                      cmd,
    output vgg_pkg::sts_t                      sts,
    input  logic [vgg_pkg::CPU_W-1:0]          cells_per_unit,
    input  logic [vgg_pkg::SIDE_W-1:0]         grid_side,
    input  logic signed [vgg_pkg::COORD_W-1:0] u_coord,
    input  logic signed [vgg_pkg::COORD_W-1:0] v_coord,
    input  logic signed [vgg_pkg::DIN_W-1:0]   vis_re,
    input  logic signed [vgg_pkg::DIN_W-1:0]   vis_im,
    input  logic signed [vgg_pkg::DIN_W-1:0]   wgt_re,
    input  logic signed [vgg_pkg::DIN_W-1:0]   wgt_im,
    input  logic [vgg_pkg::CELL_W-1:0]         cell_row,
    input  logic [vgg_pkg::CELL_W-1:0]         cell_col,
    output logic signed [vgg_pkg::ACC_W-1:0]   uv_re,
    output logic signed [vgg_pkg::ACC_W-1:0]   uv_im,
    output logic signed [vgg_pkg::ACC_W-1:0]   bm_re,
    output logic signed [vgg_pkg::ACC_W-1:0]   bm_im
);
    import vgg_pkg::*;

    localparam int DEPTH  = GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AW     = $clog2(GRID_SIDE_MAX);
    localparam int SW     = $clog2(GRID_SIDE_MAX + 1);
    localparam int EW     = (SW > SIDE_W) ? SW : SIDE_W;
    localparam int QT_W   = FRAC_W + FQ_W + 2;
    localparam int NG     = 4;

    typedef struct packed {
        logic              sign;
        logic [IPM_W-1:0]  ipm;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    // Item registers.
    logic signed [COORD_W-1:0] u_reg, v_reg;
    logic signed [DIN_W-1:0]   x_reg [NG];
    logic [CELL_W-1:0]         row_in_reg, col_in_reg;

    // Position and modulo unit.
    logic signed [POS_W-1:0]  pos_r_reg, pos_c_reg;
    axis_t                    ax_r_reg, ax_c_reg;
    logic signed [FQ_W-1:0]   fq_r_reg, fq_c_reg;
    logic [IPM_W-1:0]         src_reg;
    logic [SW:0]              rem_reg;
    logic                     div_sign_reg;
    logic [AW-1:0]            base_r_reg, base_c_reg;

    // Cell update.
    logic [ADDR_W-1:0]        addr_reg;
    logic [WT_W-1:0]          w_reg;
    logic signed [PROD_W-1:0] prod_reg [NG];
    logic                     in_range_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic signed [ACC_W-1:0]  out_reg [NG];

    logic [SW-1:0]            side_eff;
    logic [EW-1:0]            side_ext;
    logic [ACC_W-1:0]         rdata [NG];
    logic [ACC_W-1:0]         wdata [NG];
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_addr;
    logic [SW:0]              rem_sh;
    logic [SW-1:0]            rem_fix;
    logic [AW-1:0]            ri, ci;

    // Adds the side to a negative position; splits it into sign, integer magnitude and fraction magnitude.
    function automatic axis_t split_pos(input logic signed [POS_W-1:0] p,
                                        input logic [SW-1:0] side);
        logic signed [POS_W-1:0] q;
        logic [POS_W-1:0]        mag;
        axis_t                   a;
        q = p;
        if (p < 0)
        begin
            q = p + (POS_W'(side) << FRAC_W);
        end
        if (q < 0)
        begin
            mag = -q;
        end
        else
        begin
            mag = q;
        end
        a.sign = q[POS_W-1];
        a.ipm  = mag[POS_W-2:FRAC_W];
        a.frac = mag[FRAC_W-1:0];
        return a;
    endfunction

    // Rounds the signed fraction to the nearest table step, halves upwards.
    function automatic logic signed [FQ_W-1:0] quant_frac(input logic sign,
                                                          input logic [FRAC_W-1:0] frac);
        logic signed [QT_W-1:0] f;
        logic signed [QT_W-1:0] t;
        f = $signed(QT_W'(frac));
        if (sign)
        begin
            f = -f;
        end
        t = f * $signed(QT_W'(FRAC_STEPS)) + $signed(QT_W'(1) << (FRAC_W - 1));
        return FQ_W'(t >>> FRAC_W);
    endfunction

    // Cell index of a tap, wrapped once around the grid side.
    function automatic logic [AW-1:0] wrap_tap(input logic [AW-1:0] base,
                                               input logic [TAP_W-1:0] k,
                                               input logic [SW-1:0] side);
        int t;
        t = int'(base) + int'(k) - HALF_K;
        if (t < 0)
        begin
            t = t + int'(side);
        end
        else if (t >= int'(side))
        begin
            t = t - int'(side);
        end
        return AW'(t);
    endfunction

    // Rounds a product to the accumulator scale and adds with saturation.
    function automatic logic [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc,
                                                 input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        logic signed [C_W-1:0]    c;
        logic signed [ACC_W:0]    s;
        t = p + $signed(PROD_W'(1) << (WT_W - 1));
        c = C_W'(t >>> WT_W);
        s = (ACC_W + 1)'(acc) + (ACC_W + 1)'(c);
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    // Grid side in use, clamped to the supported range.
    assign side_ext = EW'(grid_side);
    always_comb
    begin
        if (side_ext < EW'(SIDE_MIN))
        begin
            side_eff = SW'(SIDE_MIN);
        end
        else if (side_ext > EW'(GRID_SIDE_MAX))
        begin
            side_eff = SW'(GRID_SIDE_MAX);
        end
        else
        begin
            side_eff = SW'(side_ext);
        end
    end

    // One restoring step of the modulo unit and the sign correction.
    assign rem_sh  = {rem_reg[SW-1:0], src_reg[IPM_W-1]};
    assign rem_fix = (div_sign_reg && (rem_reg[SW-1:0] != '0)) ?
                     (side_eff - rem_reg[SW-1:0]) : rem_reg[SW-1:0];

    assign ri = wrap_tap(base_r_reg, cmd.tap_m, side_eff);
    assign ci = wrap_tap(base_c_reg, cmd.tap_l, side_eff);

    // Payload registers of the working item and the registered position, modulo, address, product and output steps.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            u_reg      <= u_coord;
            v_reg      <= v_coord;
            x_reg[0]   <= vis_re;
            x_reg[1]   <= vis_im;
            x_reg[2]   <= wgt_re;
            x_reg[3]   <= wgt_im;
            row_in_reg <= cell_row;
            col_in_reg <= cell_col;
        end
        if (cmd.mul)
        begin
            pos_r_reg <= -(POS_W'(v_reg * $signed({1'b0, cells_per_unit})));
            pos_c_reg <= POS_W'(u_reg * $signed({1'b0, cells_per_unit}));
        end
        if (cmd.split)
        begin
            ax_r_reg <= split_pos(pos_r_reg, side_eff);
            ax_c_reg <= split_pos(pos_c_reg, side_eff);
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            if (cmd.div_axis == AXIS_ROW)
            begin
                src_reg      <= ax_r_reg.ipm;
                div_sign_reg <= ax_r_reg.sign;
                fq_r_reg     <= quant_frac(ax_r_reg.sign, ax_r_reg.frac);
            end
            else
            begin
                src_reg      <= ax_c_reg.ipm;
                div_sign_reg <= ax_c_reg.sign;
                fq_c_reg     <= quant_frac(ax_c_reg.sign, ax_c_reg.frac);
            end
        end
        if (cmd.div_step)
        begin
            src_reg <= {src_reg[IPM_W-2:0], 1'b0};
            rem_reg <= (rem_sh >= {1'b0, side_eff}) ? (rem_sh - {1'b0, side_eff}) : rem_sh;
        end
        if (cmd.div_store)
        begin
            if (cmd.div_axis == AXIS_ROW)
            begin
                base_r_reg <= AW'(rem_fix);
            end
            else
            begin
                base_c_reg <= AW'(rem_fix);
            end
        end
        // Footprint cell address and separable weight.
        if (cmd.cell_addr)
        begin
            addr_reg <= ADDR_W'(ri) * ADDR_W'(GRID_SIDE_MAX) + ADDR_W'(ci);
            w_reg    <= axis_weight(cmd.tap_m, fq_r_reg) * axis_weight(cmd.tap_l, fq_c_reg);
        end
        // Read-out cell address and range check.
        if (cmd.rd_addr)
        begin
            addr_reg     <= ADDR_W'(AW'(row_in_reg)) * ADDR_W'(GRID_SIDE_MAX)
                            + ADDR_W'(AW'(col_in_reg));
            in_range_reg <= (int'(row_in_reg) < int'(side_eff))
                            && (int'(col_in_reg) < int'(side_eff));
        end
        if (cmd.prod)
        begin
            for (int g = 0; g < NG; g++)
            begin
                prod_reg[g] <= x_reg[g] * $signed({1'b0, w_reg});
            end
        end
        if (cmd.out_load)
        begin
            for (int g = 0; g < NG; g++)
            begin
                out_reg[g] <= in_range_reg ? $signed(rdata[g]) : '0;
            end
        end
    end

    // Address sweep of the clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_we)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    // Grid write control: accumulate, clear on read-out, or clearing pass.
    assign mem_we   = cmd.clr_we || cmd.acc_we || (cmd.out_load && in_range_reg);
    assign mem_addr = cmd.clr_we ? clr_cnt_reg : addr_reg;

    for (genvar g = 0; g < NG; g++)
    begin : g_grid
        assign wdata[g] = cmd.acc_we ? sat_acc($signed(rdata[g]), prod_reg[g]) : '0;

        vgg_ram #(
            .WIDTH (ACC_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (mem_we),
            .waddr (mem_addr),
            .wdata (wdata[g]),
            .re    (cmd.mem_re),
            .raddr (addr_reg),
            .rdata (rdata[g])
        );
    end

    assign uv_re = out_reg[0];
    assign uv_im = out_reg[1];
    assign bm_re = out_reg[2];
    assign bm_im = out_reg[3];
endmodule
